// File: hdl/swas_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window anagram search package
// Request codes and field widths shared by the channel interfaces and the core.
// ----------------------------------------------------------------------------
package swas_pkg;

  localparam int REQ_W    = 2;
  localparam int SYMBOL_W = 8;

  localparam logic [REQ_W-1:0] REQ_START   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PATTERN = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TEXT    = 2'd2;

endpackage

// File: hdl/swas_in_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one request (type and symbol) per transfer.
// ----------------------------------------------------------------------------
interface swas_in_if
  import swas_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [SYMBOL_W-1:0] symbol;

  modport source (output valid, output req_type, output symbol, input ready);
  modport sink   (input valid, input req_type, input symbol, output ready);
endinterface

// File: hdl/swas_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one search result per transfer.
// ----------------------------------------------------------------------------
interface swas_out_if
  import swas_pkg::*;
();
  logic valid;
  logic ready;
  logic match;
  logic found;
  logic pattern_overflow;

  modport source (output valid, output match, output found, output pattern_overflow,
                  input ready);
  modport sink   (input valid, input match, input found, input pattern_overflow,
                  output ready);
endinterface

// File: hdl/sliding_window_anagram_search_core.sv
// Start, pattern and unknown requests go from the idle state to the finish state;
// a text byte passes through the text state first. The finish state registers
// the result once the result register is free; a new request is taken only in
// idle. The difference table has one read port and is updated by read-modify-write.
// Reset is synchronous and clears the control state and table valid bits at once,
// so no clearing pass is needed and the block is ready as reset is released.
// ----------------------------------------------------------------------------
// Sliding window anagram search core
// Reports, for each text byte, whether the window ending there is a
// permutation of the loaded pattern, plus sticky found and overflow flags.
// ----------------------------------------------------------------------------
module sliding_window_anagram_search_core
  import swas_pkg::*;
#(
  parameter int MAX_PATTERN = 64,
  parameter int ALPHABET    = 256
) (
  input  logic       clk,
  input  logic       rst,
  swas_in_if.sink    in_ch,
  swas_out_if.source out_ch
);

  localparam int SYM_W  = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int PTR_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int DIFF_W = $clog2(MAX_PATTERN + 1) + 1;
  localparam int NZ_W   = $clog2(ALPHABET + 1);
  localparam int SYM_VALUES = 2 ** SYMBOL_W;

  typedef enum logic [1:0] {ST_IDLE, ST_TEXT, ST_FINISH} state_t;

  state_t            state;
  logic [REQ_W-1:0]  req;
  logic [SYM_W-1:0]  sym;
  logic [SYM_W-1:0]  leave;
  logic [DIFF_W-1:0] sym_new;
  logic              full;
  logic [NZ_W-1:0]   nz;
  logic [LEN_W-1:0]  plen;
  logic [LEN_W-1:0]  fill;
  logic [PTR_W-1:0]  head;
  logic              found;
  logic              overflow;
  logic              out_valid;
  logic              out_match;
  logic              out_found;
  logic              out_overflow;

  logic [SYM_W-1:0]  sym_mod [SYM_VALUES];
  logic [SYM_W-1:0]  sym_in;
  logic              accept;
  logic              out_free;
  logic              finish;
  logic [LEN_W:0]    idx_diff;
  logic [LEN_W:0]    idx_sum;
  logic [PTR_W-1:0]  ring_idx;
  logic [PTR_W-1:0]  head_inc;
  logic [SYM_W-1:0]  ring_rd_data;
  logic [SYM_W-1:0]  leave_c;
  logic              tbl_rd_en;
  logic [SYM_W-1:0]  tbl_rd_addr;
  logic [DIFF_W-1:0] tbl_rd_data;
  logic              tbl_wr_en;
  logic [SYM_W-1:0]  tbl_wr_addr;
  logic [DIFF_W-1:0] tbl_wr_data;
  logic              tbl_clear;
  logic [DIFF_W-1:0] diff_inc;
  logic [DIFF_W-1:0] leave_before;
  logic [DIFF_W-1:0] leave_after;
  logic [NZ_W-1:0]   nz_fin;
  logic [LEN_W-1:0]  fill_fin;
  logic              text_match;
  logic              pat_room;

  // Keeps the nonzero-entry count in step with one table update.
  function automatic logic [NZ_W-1:0] nz_adj(input logic [NZ_W-1:0]   n,
                                              input logic [DIFF_W-1:0] b,
                                              input logic [DIFF_W-1:0] a);
    logic [NZ_W-1:0] r;
    r = n;
    if (b == '0 && a != '0) begin
      r = n + NZ_W'(1);
    end else if (b != '0 && a == '0) begin
      r = n - NZ_W'(1);
    end
    return r;
  endfunction

  for (genvar g = 0; g < SYM_VALUES; g++) begin : g_sym_mod
    assign sym_mod[g] = SYM_W'(g % ALPHABET);
  end

  swas_diff_table #(
    .DEPTH (ALPHABET),
    .ADDR_W(SYM_W),
    .DATA_W(DIFF_W)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .clear  (tbl_clear),
    .rd_en  (tbl_rd_en),
    .rd_addr(tbl_rd_addr),
    .rd_data(tbl_rd_data),
    .wr_en  (tbl_wr_en),
    .wr_addr(tbl_wr_addr),
    .wr_data(tbl_wr_data)
  );

  swas_window_ring #(
    .DEPTH (MAX_PATTERN),
    .ADDR_W(PTR_W),
    .DATA_W(SYM_W)
  ) u_ring (
    .clk    (clk),
    .rd_en  (accept),
    .rd_addr(ring_idx),
    .rd_data(ring_rd_data),
    .wr_en  (finish && req == REQ_TEXT),
    .wr_addr(head),
    .wr_data(sym)
  );

  always_comb begin
    in_ch.ready = (state == ST_IDLE);
    accept      = in_ch.valid && (state == ST_IDLE);
    out_free    = !out_valid || out_ch.ready;
    finish      = (state == ST_FINISH) && out_free;
    sym_in      = sym_mod[in_ch.symbol];
    pat_room    = (plen < LEN_W'(MAX_PATTERN));

    // Ring slot of the symbol that leaves the window: head minus pattern length.
    idx_diff = (LEN_W + 1)'(head) - (LEN_W + 1)'(plen);
    idx_sum  = idx_diff + (LEN_W + 1)'(MAX_PATTERN);
    ring_idx = idx_diff[LEN_W] ? idx_sum[PTR_W-1:0] : idx_diff[PTR_W-1:0];
    head_inc = (head == PTR_W'(MAX_PATTERN - 1)) ? '0 : head + PTR_W'(1);

    // With an empty pattern the incoming symbol leaves again at once.
    leave_c  = (plen != '0) ? ring_rd_data : sym;
    diff_inc = tbl_rd_data + DIFF_W'(1);

    // The leaving read was issued while the incoming entry was being written.
    leave_before = (leave == sym) ? sym_new : tbl_rd_data;
    leave_after  = leave_before - DIFF_W'(1);
    nz_fin       = full ? nz_adj(nz, leave_before, leave_after) : nz;
    fill_fin     = full ? fill : fill + LEN_W'(1);
    text_match   = (fill_fin == plen) && (nz_fin == '0);

    tbl_rd_en   = accept || (state == ST_TEXT);
    tbl_rd_addr = (state == ST_TEXT) ? leave_c : sym_in;
    tbl_clear   = finish && (req == REQ_START);
    tbl_wr_en   = 1'b0;
    tbl_wr_addr = sym;
    tbl_wr_data = diff_inc;
    if (state == ST_TEXT) begin
      tbl_wr_en = 1'b1;
    end else if (finish && req == REQ_PATTERN) begin
      tbl_wr_en   = pat_room;
      tbl_wr_data = tbl_rd_data - DIFF_W'(1);
    end else if (finish && req == REQ_TEXT) begin
      tbl_wr_en   = full;
      tbl_wr_addr = leave;
      tbl_wr_data = leave_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      nz           <= '0;
      plen         <= '0;
      fill         <= '0;
      head         <= '0;
      found        <= 1'b0;
      overflow     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            req   <= in_ch.req_type;
            sym   <= sym_in;
            full  <= (fill >= plen);
            state <= (in_ch.req_type == REQ_TEXT) ? ST_TEXT : ST_FINISH;
          end
        end
        ST_TEXT: begin
          leave   <= leave_c;
          sym_new <= diff_inc;
          nz      <= nz_adj(nz, tbl_rd_data, diff_inc);
          state   <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_match <= (req == REQ_TEXT) && text_match;
            state     <= ST_IDLE;
            case (req)
              REQ_START: begin
                nz           <= '0;
                plen         <= '0;
                fill         <= '0;
                head         <= '0;
                found        <= 1'b0;
                overflow     <= 1'b0;
                out_found    <= 1'b0;
                out_overflow <= 1'b0;
              end
              REQ_PATTERN: begin
                if (pat_room) begin
                  nz   <= nz_adj(nz, tbl_rd_data, tbl_rd_data - DIFF_W'(1));
                  plen <= plen + LEN_W'(1);
                end else begin
                  overflow <= 1'b1;
                end
                out_found    <= found;
                out_overflow <= overflow || !pat_room;
              end
              REQ_TEXT: begin
                nz           <= nz_fin;
                fill         <= fill_fin;
                head         <= head_inc;
                found        <= found || text_match;
                out_found    <= found || text_match;
                out_overflow <= overflow;
              end
              default: begin
                out_found    <= found;
                out_overflow <= overflow;
              end
            endcase
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.match            = out_match;
  assign out_ch.found            = out_found;
  assign out_ch.pattern_overflow = out_overflow;

  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    fill <= plen)
    else $error("window fill exceeds pattern length");

  a_plen_bound : assert property (@(posedge clk) disable iff (rst)
    plen <= LEN_W'(MAX_PATTERN))
    else $error("pattern length exceeds bound");

  a_nz_bound : assert property (@(posedge clk) disable iff (rst)
    nz <= NZ_W'(ALPHABET))
    else $error("nonzero symbol count exceeds alphabet");

  a_match_found : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_match |-> out_found)
    else $error("match reported without found flag");

  a_start_clears : assert property (@(posedge clk) disable iff (rst)
    finish && req == REQ_START |=> !found && !overflow && nz == '0 && plen == '0)
    else $error("start did not clear the search state");

endmodule

// File: hdl/swas_diff_table.sv
// ----------------------------------------------------------------------------
// Symbol difference table
// One-read, one-write synchronous memory with per-entry valid bits, so that
// a single-cycle clear makes every entry read back as zero.
// ----------------------------------------------------------------------------
module swas_diff_table #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld;
  logic [DATA_W-1:0] rd_q;

  // A read and a write to the same entry in one cycle return the old value.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= vld[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_q;

endmodule

// File: hdl/swas_window_ring.sv
// ----------------------------------------------------------------------------
// Text window ring
// Synchronous memory that holds the most recent text symbols so that the
// symbol leaving the window can be read back.
// ----------------------------------------------------------------------------
module swas_window_ring #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign rd_data = rd_q;

endmodule

// File: tb/tb_sliding_window_anagram_search_core.sv
// ----------------------------------------------------------------------------
// Sliding window anagram search core testbench
// Drives searches made of a start, pattern bytes, text bytes and unused request
// codes through the request channel with random gaps, and checks every result
// against an in-bench model of the difference table, window ring and sticky flags.
// ----------------------------------------------------------------------------
module tb_sliding_window_anagram_search_core;
  import swas_pkg::*;

  localparam int MAX_PATTERN = 64;
  localparam int ALPHABET    = 256;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TEXT_ITEMS  = 800;
  localparam int LONG_HOLD   = 300;
  localparam int HOLD_AT     = 150;

  // The package leaves the fourth request code unnamed; the core must ignore it.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic match;
    logic found;
    logic pattern_overflow;
  } search_flags_t;

  class anagram_scoreboard;
    int            sym_balance[ALPHABET];
    int            unbalanced;
    int            pat_len;
    logic [7:0]    ring[MAX_PATTERN];
    int            ring_head;
    int            ring_fill;
    logic          found_seen;
    logic          overflow_seen;
    search_flags_t awaited_flags[$];
    int            errors;

    function new();
      errors = 0;
      foreach (ring[i]) ring[i] = '0;
      restart();
    endfunction

    function void restart();
      foreach (sym_balance[i]) sym_balance[i] = 0;
      unbalanced    = 0;
      pat_len       = 0;
      ring_head     = 0;
      ring_fill     = 0;
      found_seen    = 1'b0;
      overflow_seen = 1'b0;
    endfunction

    function void shift_balance(int sym, int delta);
      int was;
      was = sym_balance[sym];
      sym_balance[sym] = was + delta;
      if (was == 0 && sym_balance[sym] != 0) unbalanced++;
      else if (was != 0 && sym_balance[sym] == 0) unbalanced--;
    endfunction

    function void note_request(logic [REQ_W-1:0] kind, logic [SYMBOL_W-1:0] sym);
      search_flags_t exp_flags;
      int            s;
      int            leaving;
      bit            full;
      s = int'(sym) % ALPHABET;
      exp_flags.match = 1'b0;
      case (kind)
        REQ_START: begin
          restart();
        end
        REQ_PATTERN: begin
          if (pat_len < MAX_PATTERN) begin
            shift_balance(s, -1);
            pat_len++;
          end else begin
            overflow_seen = 1'b1;
          end
        end
        REQ_TEXT: begin
          leaving = s;
          full    = (ring_fill >= pat_len);
          if (pat_len != 0) leaving = ring[(ring_head + MAX_PATTERN - pat_len) % MAX_PATTERN];
          shift_balance(s, 1);
          if (full) shift_balance(leaving, -1);
          else ring_fill++;
          ring[ring_head] = 8'(s);
          ring_head = (ring_head + 1) % MAX_PATTERN;
          if (ring_fill == pat_len && unbalanced == 0) begin
            exp_flags.match = 1'b1;
            found_seen      = 1'b1;
          end
        end
        default: begin
        end
      endcase
      exp_flags.found            = found_seen;
      exp_flags.pattern_overflow = overflow_seen;
      awaited_flags.push_back(exp_flags);
    endfunction

    function void check_result(search_flags_t got);
      search_flags_t want;
      if (awaited_flags.size() == 0) begin
        $error("result with no request outstanding: match %0b found %0b overflow %0b",
               got.match, got.found, got.pattern_overflow);
        errors++;
        return;
      end
      want = awaited_flags.pop_front();
      if (got.match !== want.match) begin
        $error("match: expected %0b, got %0b", want.match, got.match);
        errors++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0b, got %0b", want.found, got.found);
        errors++;
      end
      if (got.pattern_overflow !== want.pattern_overflow) begin
        $error("pattern_overflow: expected %0b, got %0b",
               want.pattern_overflow, got.pattern_overflow);
        errors++;
      end
    endfunction

    function int outstanding();
      return awaited_flags.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycles;
  int   send_calm;
  int   recv_calm;
  int   sent;

  anagram_scoreboard sb;

  swas_in_if  req_ch ();
  swas_out_if res_ch ();

  sliding_window_anagram_search_core #(
    .MAX_PATTERN(MAX_PATTERN),
    .ALPHABET   (ALPHABET)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .in_ch (req_ch),
    .out_ch(res_ch)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cycles = 0;
    send_calm = 0;
    recv_calm = 0;
    sent = 0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_START;
    req_ch.symbol   = '0;
    res_ch.ready    = 1'b0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Occasional runs of back-to-back activity between stretches of random gaps.
  function automatic int draw_idle(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 9);
  endfunction

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_result('{res_ch.match, res_ch.found, res_ch.pattern_overflow});
  end

  initial begin
    int wait_cycles;
    int taken;
    taken = 0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      // One long hold-off lets the core back up and stall its request side.
      wait_cycles = (taken == HOLD_AT) ? LONG_HOLD : draw_idle(recv_calm);
      if (wait_cycles > 0) begin
        res_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      taken++;
    end
  end

  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [SYMBOL_W-1:0] sym);
    int gap;
    gap = draw_idle(send_calm);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.symbol   <= sym;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(kind, sym);
    sent++;
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Symbols come mostly from a narrow alphabet so that windows match often.
  function automatic logic [SYMBOL_W-1:0] pick_symbol(logic [SYMBOL_W-1:0] base, int spread);
    if ($urandom_range(0, 15) == 0) return SYMBOL_W'($urandom_range(0, 255));
    return base + SYMBOL_W'($urandom_range(0, spread - 1));
  endfunction

  task automatic run_search(input int pat_count);
    logic [SYMBOL_W-1:0] base;
    int                  spread;
    int                  text_count;
    int                  roll;
    base   = SYMBOL_W'($urandom_range(0, 255));
    spread = $urandom_range(1, 4);
    send_request(REQ_START, SYMBOL_W'($urandom_range(0, 255)));
    repeat (pat_count) send_request(REQ_PATTERN, pick_symbol(base, spread));
    text_count = (pat_count > 6) ? pat_count + $urandom_range(0, 80)
                                 : pat_count * $urandom_range(2, 4) + $urandom_range(1, 8);
    repeat (text_count) begin
      roll = $urandom_range(0, 39);
      if (roll == 0) send_request(REQ_PATTERN, pick_symbol(base, spread));
      else if (roll == 1) send_request(REQ_UNUSED, SYMBOL_W'($urandom_range(0, 255)));
      else send_request(REQ_TEXT, pick_symbol(base, spread));
    end
  endtask

  initial begin
    int searches;
    int pat_count;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // An empty pattern matches every text byte.
    send_request(REQ_START, 8'h00);
    send_request(REQ_TEXT, 8'h00);
    send_request(REQ_UNUSED, 8'hFF);
    // Start clears the sticky found flag; its symbol is ignored.
    send_request(REQ_START, 8'hAA);
    send_request(REQ_PATTERN, 8'h00);
    send_request(REQ_PATTERN, 8'hFF);
    send_request(REQ_TEXT, 8'hFF);
    send_request(REQ_TEXT, 8'h00);
    send_request(REQ_TEXT, 8'h00);
    send_request(REQ_TEXT, 8'hFF);
    // A pattern byte after text widens the window again.
    send_request(REQ_PATTERN, 8'h80);
    send_request(REQ_TEXT, 8'h80);
    send_request(REQ_TEXT, 8'h7F);
    send_request(REQ_UNUSED, 8'h55);
    send_request(REQ_START, 8'h55);
    send_request(REQ_TEXT, 8'h55);
    drain_results();

    // The first search overruns the pattern store so the overflow flag is seen early.
    searches = 0;
    run_search(MAX_PATTERN + 2);
    while (sent < TEXT_ITEMS) begin
      if ($urandom_range(0, 7) == 0) pat_count = $urandom_range(7, MAX_PATTERN + 6);
      else pat_count = $urandom_range(0, 6);
      run_search(pat_count);
      searches++;
      if (searches % 6 == 0) drain_results();
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sliding_window_anagram_search_core.f
hdl/swas_pkg.sv
hdl/swas_in_if.sv
hdl/swas_out_if.sv
hdl/swas_diff_table.sv
hdl/swas_window_ring.sv
hdl/sliding_window_anagram_search_core.sv
tb/tb_sliding_window_anagram_search_core.sv
